[rtl/core/fbp_pkg.sv]
// fbp_pkg: shared types, codes and helpers for the fixed block pool core.
// No dependencies; imported by every module under rtl/core.
package fbp_pkg;

	localparam int SIZE_W   = 32;   // request_size width
	localparam int CFG_DW   = 32;   // configuration write data width
	localparam int LOG2_W   = 4;    // block_size_log2 width
	localparam int CMD_W    = 2;
	localparam int ACT_W    = 3;

	localparam logic [LOG2_W-1:0] LOG2_MIN = 4'd2;
	localparam logic [LOG2_W-1:0] LOG2_MAX = 4'd12;
	localparam logic [LOG2_W-1:0] LOG2_RST = 4'd4;

	// configuration register indexes
	localparam logic [0:0] REG_POOL_BASE  = 1'b0;
	localparam logic [0:0] REG_BLOCK_LOG2 = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REALLOC = 2'd2
	} cmd_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_GRANT        = 3'd0,
		ACT_HEAP_ALLOC   = 3'd1,
		ACT_FREED        = 3'd2,
		ACT_HEAP_FREE    = 3'd3,
		ACT_KEPT         = 3'd4,
		ACT_HEAP_REALLOC = 3'd5,
		ACT_MOVE_OUT     = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	// address decode flags handed from the decoder to the engine
	typedef struct packed {
		logic in_pool;
		logic fits;
	} dec_t;

	// block size exponent clamped to the supported range
	function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] raw);
		logic [LOG2_W-1:0] r;
		r = raw;
		if (raw < LOG2_MIN)
			r = LOG2_MIN;
		else if (raw > LOG2_MAX)
			r = LOG2_MAX;
		return r;
	endfunction

endpackage

[rtl/core/fixed_block_free_list_pool_core.sv]
// fixed_block_free_list_pool_core: top level of the fixed block pool allocator.
// Depends on fbp_pkg, fbp_addr_map, fbp_engine (and fbp_link_mem below it).
//
//  channel  | direction | beat contents
//  s_*      | in        | tuser: command; tdata: request_size, block_addr, heap_ok
//  m_*      | out       | tuser: action; tdata: result_addr, in_use_count, peak_in_use
//  cfg_*    | in        | cfg_index: register (0 pool_base, 1 block_size_log2), cfg_data
//
// Each command runs as decode plus link memory read, then execute.
// The registered link memory read and the updated free head call for that split.
// After reset the link store is chained in order by a pass over all NUM_BLOCKS entries,
// during which s_tready stays low; configuration writes are taken at any time.
// Execute of a command with a result holds while the output register is full and m_tready is low.
module fixed_block_free_list_pool_core
	import fbp_pkg::*;
#(
	parameter int NUM_BLOCKS = 256,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [SIZE_W-1:0] request_size, then block_addr, then heap_ok, zero padded
	input  logic [((SIZE_W+ADDR_WIDTH+1+7)/8)*8-1:0] s_tdata,
	// command
	input  logic [CMD_W-1:0]    s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// result_addr, then in_use_count, then peak_in_use, zero padded
	output logic [((ADDR_WIDTH+2*$clog2(NUM_BLOCKS+1)+7)/8)*8-1:0] m_tdata,
	// action
	output logic [ACT_W-1:0]    m_tuser,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data
);

	localparam int IW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW     = $clog2(NUM_BLOCKS + 1);
	localparam int OUT_DW = ((ADDR_WIDTH + 2*CW + 7)/8)*8;
	localparam int ADDR_LO = SIZE_W;
	localparam int OK_BIT  = SIZE_W + ADDR_WIDTH;

	logic [ADDR_WIDTH-1:0] base_q;
	logic [LOG2_W-1:0]     log2_q;

	logic [SIZE_W-1:0]     req_size;
	logic [ADDR_WIDTH-1:0] req_addr;
	dec_t                  dec;
	logic [IW-1:0]         blk_idx;
	logic [ADDR_WIDTH-1:0] grant_addr;
	logic [CW-1:0]         free_head;

	logic [ACT_W-1:0]      res_action;
	logic [ADDR_WIDTH-1:0] res_addr;
	logic [CW-1:0]         res_in_use, res_peak;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			log2_q <= LOG2_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POOL_BASE:  base_q <= ADDR_WIDTH'(cfg_data);
				REG_BLOCK_LOG2: log2_q <= cfg_data[LOG2_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req_size = s_tdata[SIZE_W-1:0];
	assign req_addr = s_tdata[ADDR_LO +: ADDR_WIDTH];

	fbp_addr_map #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.ADDR_WIDTH (ADDR_WIDTH),
		.IW         (IW),
		.CW         (CW)
	) u_addr_map (
		.pool_base       (base_q),
		.block_size_log2 (log2_q),
		.block_addr      (req_addr),
		.request_size    (req_size),
		.free_head       (free_head),
		.dec             (dec),
		.blk_idx         (blk_idx),
		.grant_addr      (grant_addr)
	);

	fbp_engine #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.ADDR_WIDTH (ADDR_WIDTH),
		.IW         (IW),
		.CW         (CW)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_cmd        (s_tuser),
		.in_addr       (req_addr),
		.in_heap_ok    (s_tdata[OK_BIT]),
		.in_dec        (dec),
		.in_idx        (blk_idx),
		.in_grant_addr (grant_addr),
		.free_head     (free_head),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_action    (res_action),
		.out_addr      (res_addr),
		.out_in_use    (res_in_use),
		.out_peak      (res_peak)
	);

	assign m_tuser = res_action;
	assign m_tdata = OUT_DW'({res_peak, res_in_use, res_addr});

endmodule

[rtl/core/fbp_link_mem.sv]
// fbp_link_mem: free list link store, one write and one registered read port.
// Uses fbp_pkg only for house consistency; no submodules.
module fbp_link_mem
	import fbp_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int IW    = 8,
	parameter int DW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[rtl/core/fbp_addr_map.sv]
// fbp_addr_map: pool membership, block index, size fit and grant address.
// Depends on fbp_pkg (dec_t, eff_log2, SIZE_W).
module fbp_addr_map
	import fbp_pkg::*;
#(
	parameter int NUM_BLOCKS = 256,
	parameter int ADDR_WIDTH = 32,
	parameter int IW         = 8,
	parameter int CW         = 9
) (
	input  logic [ADDR_WIDTH-1:0] pool_base,
	input  logic [LOG2_W-1:0]     block_size_log2,
	input  logic [ADDR_WIDTH-1:0] block_addr,
	input  logic [SIZE_W-1:0]     request_size,
	input  logic [CW-1:0]         free_head,
	output dec_t                  dec,
	output logic [IW-1:0]         blk_idx,
	output logic [ADDR_WIDTH-1:0] grant_addr
);

	logic [LOG2_W-1:0]     lg;
	logic [ADDR_WIDTH-1:0] off;
	logic [ADDR_WIDTH-1:0] off_sh;
	logic [SIZE_W-1:0]     bsize;

	always_comb begin
		lg     = eff_log2(block_size_log2);
		off    = block_addr - pool_base;
		// offset in blocks; in pool when the address is not below the base and this stays below the block count
		off_sh = off >> lg;
		bsize  = SIZE_W'(1) << lg;
		dec.in_pool = (block_addr >= pool_base) &&
			({1'b0, off_sh} < (ADDR_WIDTH+1)'(NUM_BLOCKS));
		dec.fits    = (request_size <= bsize);
		blk_idx     = off_sh[IW-1:0];
		grant_addr  = pool_base + (ADDR_WIDTH'(free_head) << lg);
	end

endmodule

[rtl/core/fbp_engine.sv]
// fbp_engine: command sequencer, free head, usage counters and output register.
// Depends on fbp_pkg and fbp_link_mem.
module fbp_engine
	import fbp_pkg::*;
#(
	parameter int NUM_BLOCKS = 256,
	parameter int ADDR_WIDTH = 32,
	parameter int IW         = 8,
	parameter int CW         = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input beat, already decoded
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      in_cmd,
	input  logic [ADDR_WIDTH-1:0] in_addr,
	input  logic                  in_heap_ok,
	input  dec_t                  in_dec,
	input  logic [IW-1:0]         in_idx,
	input  logic [ADDR_WIDTH-1:0] in_grant_addr,
	output logic [CW-1:0]         free_head,
	// result beat
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ACT_W-1:0]      out_action,
	output logic [ADDR_WIDTH-1:0] out_addr,
	output logic [CW-1:0]         out_in_use,
	output logic [CW-1:0]         out_peak
);

	localparam logic [CW-1:0] NB = CW'(NUM_BLOCKS);

	state_t                state_q;
	logic [IW-1:0]         clr_q;
	logic [CW-1:0]         head_q, live_q, peak_q;

	cmd_t                  cmd_s1;
	logic [ADDR_WIDTH-1:0] addr_s1, grant_s1;
	logic                  heap_ok_s1;
	dec_t                  dec_s1;
	logic [IW-1:0]         idx_s1;

	logic                  out_valid_q;
	action_t               out_action_q;
	logic [ADDR_WIDTH-1:0] out_addr_q;
	logic [CW-1:0]         out_in_use_q, out_peak_q;

	logic                  accept, exec_done, has_res, push, pop, head_null;
	action_t               act;
	logic [ADDR_WIDTH-1:0] raddr_res;
	logic [CW-1:0]         head_d, live_d, peak_d;
	logic [CW-1:0]         link_rdata;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [CW-1:0]         mem_wdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign free_head = head_q;
	assign head_null = (head_q >= NB);

	always_comb begin
		head_d    = head_q;
		live_d    = live_q;
		peak_d    = peak_q;
		act       = ACT_HEAP_ALLOC;
		raddr_res = '0;
		push      = 1'b0;
		pop       = 1'b0;
		has_res   = 1'b1;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (dec_s1.fits && !head_null) begin
					pop       = 1'b1;
					act       = ACT_GRANT;
					raddr_res = grant_s1;
				end
			end
			CMD_FREE: begin
				if (dec_s1.in_pool) begin
					push = 1'b1;
					act  = ACT_FREED;
				end else begin
					act  = ACT_HEAP_FREE;
				end
			end
			CMD_REALLOC: begin
				if (!dec_s1.in_pool) begin
					act = ACT_HEAP_REALLOC;
				end else if (dec_s1.fits) begin
					act       = ACT_KEPT;
					raddr_res = addr_s1;
				end else begin
					act  = ACT_MOVE_OUT;
					push = heap_ok_s1;
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
		if (pop) begin
			head_d = link_rdata;
			if (live_q < NB)
				live_d = live_q + CW'(1);
			if (live_d > peak_q)
				peak_d = live_d;
		end
		if (push) begin
			head_d = CW'(idx_s1);
			if (live_q != '0)
				live_d = live_q - CW'(1);
		end
	end

	// a command with no result never waits on the output register
	assign exec_done = (state_q == ST_EXEC) && (!has_res || !out_valid_q || out_ready);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = CW'({1'b0, clr_q}) + CW'(1);
		end else begin
			mem_we    = exec_done && push;
			mem_waddr = idx_s1;
			mem_wdata = head_q;
		end
	end

	fbp_link_mem #(
		.DEPTH (NUM_BLOCKS),
		.IW    (IW),
		.DW    (CW)
	) u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept && !head_null),
		.raddr (head_q[IW-1:0]),
		.rdata (link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			live_q  <= '0;
			peak_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(NUM_BLOCKS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_done) begin
						state_q <= ST_IDLE;
						head_q  <= head_d;
						live_q  <= live_d;
						peak_q  <= peak_d;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_t'(in_cmd);
			addr_s1    <= in_addr;
			grant_s1   <= in_grant_addr;
			heap_ok_s1 <= in_heap_ok;
			dec_s1     <= in_dec;
			idx_s1     <= in_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (exec_done && has_res)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_done && has_res) begin
			out_action_q <= act;
			out_addr_q   <= raddr_res;
			out_in_use_q <= live_d;
			out_peak_q   <= peak_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_action = out_action_q;
	assign out_addr   = out_addr_q;
	assign out_in_use = out_in_use_q;
	assign out_peak   = out_peak_q;

`ifndef NO_ASSERTIONS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= NB)
		else $error("in-use count above block count");

	a_peak_cover: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= live_q)
		else $error("peak below in-use count");

	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> peak_q >= $past(peak_q))
		else $error("peak decreased");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NB)
		else $error("free head beyond null link");

	// a list looped by double frees may pop with the count already saturated
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_done && pop) |-> (head_q < NB))
		else $error("pop from empty free list");
`endif

endmodule

[tb/sv/fixed_block_free_list_pool_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for fixed_block_free_list_pool_core: a directed pass, then randomised phases of
// allocate/free/reallocate traffic under several pool mappings, checked beat by beat
// against a free list tracker held in a small class. Depends on fbp_pkg and the RTL.
module fixed_block_free_list_pool_core_tb;
	import fbp_pkg::*;

	localparam int NB  = 256;
	localparam int AW  = 32;
	localparam int CW  = $clog2(NB + 1);
	localparam int SDW = ((SIZE_W + AW + 1 + 7) / 8) * 8;
	localparam int MDW = ((AW + 2 * CW + 7) / 8) * 8;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		action_t         act;
		logic [AW-1:0]   addr;
		logic [CW-1:0]   used;
		logic [CW-1:0]   peak;
	} pool_reply_t;

	// Free list tracker: mirrors the head, links and counts, queues due replies.
	class pool_tracker;
		logic [31:0]   base;
		logic [3:0]    lg_raw;
		int unsigned   head;
		int unsigned   link[NB];
		int unsigned   live;
		int unsigned   peak;
		bit            on_loan[NB];
		pool_reply_t   replies_due[$];
		int unsigned   faults;

		function new();
			base = '0;
			lg_raw = LOG2_RST;
			head = 0;
			for (int i = 0; i < NB; i++) begin
				link[i] = i + 1;
				on_loan[i] = 0;
			end
			live = 0;
			peak = 0;
			faults = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [31:0] val);
			if (idx == REG_POOL_BASE)
				base = val;
			else
				lg_raw = val[3:0];
		endfunction

		function int unsigned eff_lg();
			if (lg_raw < LOG2_MIN)
				return LOG2_MIN;
			if (lg_raw > LOG2_MAX)
				return LOG2_MAX;
			return lg_raw;
		endfunction

		function logic [31:0] block_address(int unsigned idx, longint unsigned off);
			logic [63:0] a;
			a = 64'(base);
			a = a + (64'(idx) << eff_lg()) + off;
			return a[31:0];
		endfunction

		// membership is compared without wrap-around
		function bit locate(logic [31:0] addr, output int unsigned idx);
			longint unsigned off;
			longint unsigned ext;
			idx = 0;
			if (addr < base)
				return 0;
			off = 64'(addr);
			off = off - 64'(base);
			ext = NB;
			ext = ext << eff_lg();
			if (off >= ext)
				return 0;
			idx = 32'(off >> eff_lg());
			return 1;
		endfunction

		function void release_block(int unsigned idx);
			link[idx] = head;
			head = idx;
			on_loan[idx] = 0;
			if (live > 0)
				live--;
		endfunction

		function bit pick_held(output int unsigned idx);
			int unsigned cnt;
			int unsigned k;
			cnt = 0;
			idx = 0;
			foreach (on_loan[i])
				if (on_loan[i])
					cnt++;
			if (cnt == 0)
				return 0;
			k = $urandom_range(0, cnt - 1);
			foreach (on_loan[i])
				if (on_loan[i]) begin
					if (k == 0) begin
						idx = i;
						return 1;
					end
					k--;
				end
			return 0;
		endfunction

		// called once per accepted input beat
		function void apply_command(logic [CMD_W-1:0] cmd, logic [31:0] size,
				logic [31:0] addr, logic hok);
			pool_reply_t rep;
			int unsigned idx;
			longint unsigned bsize;
			bsize = 64'd1 << eff_lg();
			rep.addr = '0;
			if (cmd == CMD_ALLOC) begin
				if (size > bsize || head >= NB) begin
					rep.act = ACT_HEAP_ALLOC;
				end else begin
					idx = head;
					head = link[idx];
					if (head > NB)
						head = NB;
					on_loan[idx] = 1;
					if (live < NB)
						live++;
					if (live > peak)
						peak = live;
					rep.addr = block_address(idx, 0);
					rep.act = ACT_GRANT;
				end
			end else if (cmd == CMD_FREE) begin
				if (locate(addr, idx)) begin
					release_block(idx);
					rep.act = ACT_FREED;
				end else begin
					rep.act = ACT_HEAP_FREE;
				end
			end else if (cmd == CMD_REALLOC) begin
				if (!locate(addr, idx)) begin
					rep.act = ACT_HEAP_REALLOC;
				end else if (size <= bsize) begin
					rep.addr = addr;
					rep.act = ACT_KEPT;
				end else begin
					// failed heap move leaves the block on loan
					if (hok)
						release_block(idx);
					rep.act = ACT_MOVE_OUT;
				end
			end else begin
				return;
			end
			rep.used = live[CW-1:0];
			rep.peak = peak[CW-1:0];
			replies_due.push_back(rep);
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= 10)
				$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		function void match_reply(logic [ACT_W-1:0] act, logic [AW-1:0] addr,
				logic [CW-1:0] used, logic [CW-1:0] pk);
			pool_reply_t rep;
			if (replies_due.size() == 0) begin
				flag($sformatf("unexpected beat action %0d addr %h used %0d peak %0d",
					act, addr, used, pk));
				return;
			end
			rep = replies_due.pop_front();
			if (act !== rep.act || addr !== rep.addr || used !== rep.used || pk !== rep.peak)
				flag($sformatf("exp action %0d addr %h used %0d peak %0d, got %0d %h %0d %0d",
					rep.act, rep.addr, rep.used, rep.peak, act, addr, used, pk));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [SDW-1:0]   s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [MDW-1:0]   m_tdata;
	logic [ACT_W-1:0] m_tuser;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [0:0]       cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	pool_tracker tracker = new();
	bit          steady = 0;

	fixed_block_free_list_pool_core #(
		.NUM_BLOCKS(NB),
		.ADDR_WIDTH(AW)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: check each beat, then choose the next tready
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready)
			tracker.match_reply(m_tuser, m_tdata[AW-1:0], m_tdata[AW+CW-1:AW],
				m_tdata[AW+2*CW-1:AW+CW]);
		m_tready <= steady || ($urandom_range(0, 99) >= 16);
	end

	task automatic issue_request(logic [CMD_W-1:0] cmd, logic [31:0] size,
			logic [31:0] addr, logic hok);
		if (!steady)
			while ($urandom_range(0, 99) < 16) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= SDW'({hok, addr, size});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.apply_command(cmd, size, addr, hok);
	endtask

	task automatic write_register(logic [0:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tracker.set_reg(idx, val);
	endtask

	// hold the sender until every reply is in
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (tracker.replies_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_size();
		int unsigned r;
		logic [31:0] bsize;
		r = $urandom_range(0, 99);
		bsize = 32'd1 << tracker.eff_lg();
		if (r < 75)
			return $urandom_range(0, bsize);
		if (r < 85)
			return bsize + 1;
		if (r < 95)
			return $urandom;
		return '1;
	endfunction

	function automatic logic [31:0] pick_addr();
		int unsigned r;
		int unsigned idx;
		int unsigned lg;
		logic [63:0] ext;
		r = $urandom_range(0, 99);
		lg = tracker.eff_lg();
		ext = 64'(NB) << lg;
		if (r < 70 && tracker.pick_held(idx))
			return tracker.block_address(idx,
				$urandom_range(0, 1) ? 0 : $urandom_range(0, (1 << lg) - 1));
		if (r < 80)
			return $urandom;
		if (r < 90)
			return tracker.block_address($urandom_range(0, NB - 1), 0);
		case ($urandom_range(0, 2))
			0: return tracker.base - 1;
			1: return tracker.block_address(0, ext);
			default: return tracker.block_address(0, ext - 1);
		endcase
	endfunction

	task automatic random_phase(int unsigned beats, int unsigned alloc_pct);
		int unsigned n;
		int unsigned r;
		n = 0;
		while (n < beats) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct) begin
				issue_request(CMD_ALLOC, pick_size(), $urandom, $urandom_range(0, 1));
				n++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					issue_request(CMD_UNUSED, $urandom, $urandom, $urandom_range(0, 1));
				end else if (r < 62) begin
					issue_request(CMD_FREE, $urandom, pick_addr(), $urandom_range(0, 1));
					n++;
				end else begin
					issue_request(CMD_REALLOC, pick_size(), pick_addr(), $urandom_range(0, 1));
					n++;
				end
			end
		end
	endtask

	initial begin
		logic [31:0] bases[8];
		logic [3:0]  lgs[8];
		int unsigned allocs[8];
		logic [31:0] word;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_ALLOC;
		cfg_valid <= 1'b0;
		cfg_index <= REG_POOL_BASE;
		cfg_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass at reset mapping: base 0, 16 byte blocks
		issue_request(CMD_ALLOC, 32'd1, 32'd0, 1'b0);
		issue_request(CMD_ALLOC, 32'd16, 32'hFFFF_FFFF, 1'b1);
		issue_request(CMD_ALLOC, 32'd17, 32'd0, 1'b0);
		issue_request(CMD_ALLOC, 32'd0, 32'd0, 1'b0);
		issue_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b0);
		issue_request(CMD_FREE, 32'd0, 32'h13, 1'b0);          // unaligned, block 1
		issue_request(CMD_FREE, 32'd0, 32'hFFFF_FFFF, 1'b0);
		issue_request(CMD_FREE, 32'd0, 32'h1000, 1'b0);        // just past the pool
		issue_request(CMD_FREE, 32'd0, 32'hFFF, 1'b0);         // never granted
		issue_request(CMD_REALLOC, 32'd16, 32'h20, 1'b0);
		issue_request(CMD_REALLOC, 32'd0, 32'h24, 1'b1);
		issue_request(CMD_REALLOC, 32'd17, 32'h0, 1'b0);       // heap failed, stays
		issue_request(CMD_REALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1);
		issue_request(CMD_REALLOC, 32'd4, 32'h5000, 1'b1);
		issue_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		issue_request(CMD_FREE, 32'd0, 32'h20, 1'b0);
		issue_request(CMD_FREE, 32'd0, 32'h20, 1'b0);          // double free
		issue_request(CMD_FREE, 32'd0, 32'h10, 1'b0);
		issue_request(CMD_FREE, 32'd0, 32'h10, 1'b0);          // count floors at zero
		issue_request(CMD_ALLOC, 32'd1, 32'd0, 1'b0);
		issue_request(CMD_ALLOC, 32'd1, 32'd0, 1'b0);
		issue_request(CMD_REALLOC, 32'd1, 32'hFFFF_FFFF, 1'b1);
		drain_replies();

		bases  = '{32'h0000_1000, 32'hFFFF_F000, 32'h8000_0000, $urandom,
			32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h0000_0000};
		lgs    = '{4'd2, 4'd12, 4'd12, 4'd0, 4'd15, 4'd3, 4'($urandom_range(0, 15)), 4'd4};
		allocs = '{60, 70, 95, 20, 90, 30, 60, 50};
		for (int p = 0; p < 8; p++) begin
			write_register(REG_POOL_BASE, bases[p]);
			word = $urandom;
			word[3:0] = lgs[p];
			write_register(REG_BLOCK_LOG2, word);
			steady = (p == 4);
			random_phase(240, allocs[p]);
			drain_replies();
		end
		steady = 0;

		repeat (10) @(posedge clk);
		if (tracker.faults == 0 && tracker.replies_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
